// ----- design/cusum_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cusum_pkg
// Shared types and constants for the two-sided CUSUM change detector.
// ----------------------------------------------------------------------------
package cusum_pkg;

    // Fixed field widths
    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int FRAC_BITS_DEF = 16;

    // Divider: 33-bit magnitude of (sample - mean), one quotient bit per cycle
    localparam int DIV_STEPS    = DATA_W + 1;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    // Command codes carried by the func field
    localparam logic [FUNC_W-1:0] FUNC_OBSERVE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESET   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT     = 1'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture a new item
        logic prep;      // form |sample - mean| and arm the divider
        logic div_step;  // one restoring division step
        logic mean;      // apply signed quotient to the mean
        logic sums;      // update both cumulative sums
        logic emit;      // load the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_observe;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage : cusum_pkg
`default_nettype wire

// ----- design/cusum_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cusum_if
// Valid/ready channel interfaces: sample input, result output, config write.
// ----------------------------------------------------------------------------
interface cusum_in_if import cusum_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] sample;

    modport source (output valid, func, sample, input ready);
    modport sink   (input valid, func, sample, output ready);
endinterface : cusum_in_if

interface cusum_out_if import cusum_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              alarm;
    logic [DATA_W-1:0] pos_sum;
    logic [DATA_W-1:0] neg_sum;

    modport source (output valid, alarm, pos_sum, neg_sum, input ready);
    modport sink   (input valid, alarm, pos_sum, neg_sum, output ready);
endinterface : cusum_out_if

interface cusum_cfg_if import cusum_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface : cusum_cfg_if
`default_nettype wire

// ----- design/cusum_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cusum_ctrl
// Sequencer: accept, divide, update mean and sums (observe items only), then hand off the result.
// ----------------------------------------------------------------------------
module cusum_ctrl
    import cusum_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_in_valid,
    output logic   o_in_ready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_DIV  = 6'b000100,
        S_MEAN = 6'b001000,
        S_SUM  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                // non-observe commands go straight to the result
                if (i_stat.is_observe) begin
                    o_cmd.prep = 1'b1;
                    n_state    = S_DIV;
                end else begin
                    n_state    = S_EMIT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.mean = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sums = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule : cusum_ctrl
`default_nettype wire

// ----- design/cusum_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cusum_dp
// Datapath: config registers, running mean and count, serial divider,
// cumulative sums and the result register.
// ----------------------------------------------------------------------------
module cusum_dp
    import cusum_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // command / status
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    // input item payload
    input  wire [FUNC_W-1:0]         i_func,
    input  wire signed [DATA_W-1:0]  i_sample,
    // configuration writes
    input  wire                      i_cfg_we,
    input  wire [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [DATA_W-1:0]         i_cfg_data,
    // result
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic                     o_alarm,
    output logic [DATA_W-1:0]        o_pos_sum,
    output logic [DATA_W-1:0]        o_neg_sum
);

    localparam logic [DATA_W-1:0] ThrReset   = DATA_W'(64'd5 << FRAC_BITS);
    localparam logic [DATA_W-1:0] DriftReset = DATA_W'((64'd1 << FRAC_BITS) >> 1);
    localparam logic [DATA_W-1:0] CountMax   = '1;
    localparam int                SumW       = DATA_W + 3;

    // Config and persistent state
    logic [DATA_W-1:0]        r_thr;
    logic [DATA_W-1:0]        r_drift;
    logic [DATA_W-1:0]        r_count;
    logic signed [DATA_W-1:0] r_mean;
    logic [DATA_W-1:0]        r_up;
    logic [DATA_W-1:0]        r_dn;
    logic                     r_out_valid;

    // Per-item payload
    logic [FUNC_W-1:0]        r_func;
    logic signed [DATA_W-1:0] r_sample;
    logic [DATA_W:0]          r_quo;   // dividend in, quotient out
    logic [DATA_W-1:0]        r_rem;
    logic                     r_neg;
    logic [DIV_CNT_W-1:0]     r_div_cnt;

    // Combinational terms
    logic signed [DATA_W:0]   diff;
    logic [DATA_W:0]          rem_sh;
    logic [DATA_W+1:0]        trial;
    logic signed [DATA_W+1:0] q_signed;
    logic signed [DATA_W+1:0] mean_new;
    logic signed [DATA_W:0]   z;
    logic signed [SumW-1:0]   up_t;
    logic signed [SumW-1:0]   dn_t;
    logic                     zero_sums;
    logic [DATA_W-1:0]        up_res;
    logic [DATA_W-1:0]        dn_res;

    function automatic logic [DATA_W-1:0] clip_sum(input logic signed [SumW-1:0] v);
        logic [DATA_W-1:0] res;
        if (v[SumW-1]) begin
            res = '0;
        end else if (v[SumW-2:DATA_W] != '0) begin
            res = '1;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    // Difference to the mean, restoring division step
    always_comb begin
        diff   = {r_sample[DATA_W-1], r_sample} - {r_mean[DATA_W-1], r_mean};
        rem_sh = {r_rem, r_quo[DATA_W]};
        trial  = {1'b0, rem_sh} - {2'b00, r_count};
    end

    // Mean and sum updates
    always_comb begin
        q_signed = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        mean_new = {{2{r_mean[DATA_W-1]}}, r_mean} + q_signed;
        z        = {r_sample[DATA_W-1], r_sample} - {r_mean[DATA_W-1], r_mean};
        up_t     = $signed({3'b000, r_up}) + {{2{z[DATA_W]}}, z}
                 - $signed({3'b000, r_drift});
        dn_t     = $signed({3'b000, r_dn}) - {{2{z[DATA_W]}}, z}
                 - $signed({3'b000, r_drift});
    end

    // Result values; reset and clear show zeroed sums
    always_comb begin
        zero_sums = (r_func == FUNC_RESET) || (r_func == FUNC_CLEAR);
        up_res    = zero_sums ? '0 : r_up;
        dn_res    = zero_sums ? '0 : r_dn;
    end

    // Status
    always_comb begin
        o_stat.is_observe = (r_func == FUNC_OBSERVE);
        o_stat.div_done   = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= ThrReset;
            r_drift <= DriftReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr   <= i_cfg_data;
                CFG_DRIFT:     r_drift <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Persistent detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mean  <= '0;
            r_up    <= '0;
            r_dn    <= '0;
        end else begin
            if (i_cmd.load && (i_func == FUNC_OBSERVE) && (r_count != CountMax)) begin
                r_count <= r_count + DATA_W'(1);
            end
            if (i_cmd.mean) begin
                r_mean <= mean_new[DATA_W-1:0];
            end
            if (i_cmd.sums) begin
                r_up <= clip_sum(up_t);
                r_dn <= clip_sum(dn_t);
            end
            if (i_cmd.emit && zero_sums) begin
                r_up <= '0;
                r_dn <= '0;
            end
            if (i_cmd.emit && (r_func == FUNC_CLEAR)) begin
                r_count <= '0;
                r_mean  <= '0;
            end
        end
    end

    // Item capture and serial divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_sample <= i_sample;
        end
        if (i_cmd.prep) begin
            r_neg     <= diff[DATA_W];
            r_quo     <= diff[DATA_W] ? $unsigned(-diff) : $unsigned(diff);
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            if (trial[DATA_W+1]) begin
                r_rem <= rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-1:0], 1'b0};
            end else begin
                r_rem <= trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-1:0], 1'b1};
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_alarm   <= (up_res > r_thr) || (dn_res > r_thr);
            o_pos_sum <= up_res;
            o_neg_sum <= dn_res;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule : cusum_dp
`default_nettype wire

// ----- design/cusum_change_detector.sv -----
// Sequence: an accepted observe item goes through prep, 33 divider steps,
//   mean, sums and the result load; reset, clear and unused commands go
//   from prep straight to the load. The divider yields one quotient bit
//   per cycle. No item is taken before the load; a waiting result stalls it.
// Reset: synchronous active-low i_rst_n zeroes mean, count and sums and
//   restores threshold 5.0 and drift 0.5 in the current fixed-point format.
`default_nettype none
// ----------------------------------------------------------------------------
// cusum_change_detector
// Two-sided CUSUM change detector with a running-mean reference level.
// ----------------------------------------------------------------------------
module cusum_change_detector
    import cusum_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    cusum_in_if.sink     i_in,
    cusum_out_if.source  o_out,
    cusum_cfg_if.sink    i_cfg
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // Configuration port never stalls
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    // Sequencer
    cusum_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath
    cusum_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_func      (i_in.func),
        .i_sample    (i_in.sample),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_alarm     (o_out.alarm),
        .o_pos_sum   (o_out.pos_sum),
        .o_neg_sum   (o_out.neg_sum)
    );

`ifndef SYNTHESIS
    // An accepted item blocks the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted item");

    // Zero sums can never exceed the threshold
    a_no_alarm_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.pos_sum == '0) && (o_out.neg_sum == '0)) |-> !o_out.alarm)
        else $error("alarm raised with both sums zero");

    // A result only appears from the emit command
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(cmd.emit))
        else $error("result valid without an emit command");
`endif

endmodule : cusum_change_detector
`default_nettype wire

// ----- verif/tb_cusum_change_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cusum_change_detector
// Self-checking bench for the two-sided CUSUM change detector. A scoreboard
// keeps its own running mean, sample count and both clipped sums, predicts
// the result of every accepted item and compares each returned result field
// by field. Stimulus is a short directed set of corner cases and then random
// sample streams (level shifts, noise, extremes, commands) under several
// threshold and drift settings, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_cusum_change_detector;
    import cusum_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 270;
    localparam int NUM_PHASES    = 7;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [DATA_W-1:0] WORD_MAX    = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] POS_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_MIN     = 32'h8000_0000;

    typedef struct packed {
        logic              alarm;
        logic [DATA_W-1:0] pos_sum;
        logic [DATA_W-1:0] neg_sum;
    } t_cusum_result;

    // Tracks detector state and queues the expected result of every item
    class t_cusum_scoreboard;
        logic [DATA_W-1:0]        threshold;
        logic [DATA_W-1:0]        drift;
        logic signed [DATA_W-1:0] mean;
        logic [DATA_W-1:0]        count;
        logic [DATA_W-1:0]        up_sum;
        logic [DATA_W-1:0]        dn_sum;
        t_cusum_result            expected_q[$];
        int unsigned              errors;
        int unsigned              n_observe;
        int unsigned              n_command;
        int unsigned              n_alarm;
        int unsigned              n_sat;
        int unsigned              n_cfg;

        function new();
            threshold = 32'd5 << FRAC_BITS_DEF;
            drift     = (32'd1 << FRAC_BITS_DEF) >> 1;
            mean      = '0;
            count     = '0;
            up_sum    = '0;
            dn_sum    = '0;
            errors    = 0;
            n_observe = 0;
            n_command = 0;
            n_alarm   = 0;
            n_sat     = 0;
            n_cfg     = 0;
        endfunction

        function logic [DATA_W-1:0] clip_sum(longint v);
            if (v < 0)
                return '0;
            if (v > longint'(WORD_MAX))
                return WORD_MAX;
            return v[DATA_W-1:0];
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
                $display("[%0t] ERROR: %s", $realtime, msg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            n_cfg++;
            if (idx == CFG_THRESHOLD)
                threshold = val;
            else if (idx == CFG_DRIFT)
                drift = val;
        endfunction

        // Predict the result of one accepted item
        function void note_input(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] x);
            longint        diff;
            longint        mean_next;
            longint        z;
            t_cusum_result want;
            case (f)
                FUNC_OBSERVE: begin
                    n_observe++;
                    if (count != WORD_MAX)
                        count++;
                    diff      = longint'(x) - longint'(mean);
                    mean_next = longint'(mean) + diff / longint'(count);
                    mean      = mean_next[DATA_W-1:0];
                    z         = longint'(x) - mean_next;
                    up_sum    = clip_sum(longint'(up_sum) + z - longint'(drift));
                    dn_sum    = clip_sum(longint'(dn_sum) - z - longint'(drift));
                end
                FUNC_RESET: begin
                    n_command++;
                    up_sum = '0;
                    dn_sum = '0;
                end
                FUNC_CLEAR: begin
                    n_command++;
                    up_sum = '0;
                    dn_sum = '0;
                    count  = '0;
                    mean   = '0;
                end
                default: n_command++;  // unused code: state unchanged
            endcase
            want.alarm   = (up_sum > threshold) || (dn_sum > threshold);
            want.pos_sum = up_sum;
            want.neg_sum = dn_sum;
            if (want.alarm)
                n_alarm++;
            if (up_sum == WORD_MAX || dn_sum == WORD_MAX)
                n_sat++;
            expected_q.push_back(want);
        endfunction

        function void check_result(t_cusum_result got);
            t_cusum_result want;
            if (expected_q.size() == 0) begin
                note_error($sformatf("result with nothing expected: alarm=%0b pos=%h neg=%h",
                                     got.alarm, got.pos_sum, got.neg_sum));
                return;
            end
            want = expected_q.pop_front();
            if (got.alarm !== want.alarm || got.pos_sum !== want.pos_sum ||
                got.neg_sum !== want.neg_sum)
                note_error($sformatf("alarm exp %0b got %0b, pos exp %h got %h, neg exp %h got %h",
                                     want.alarm, got.alarm, want.pos_sum, got.pos_sum,
                                     want.neg_sum, got.neg_sum));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_empty();
            if (expected_q.size() != 0)
                note_error($sformatf("%0d results never arrived", expected_q.size()));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   gaps_on   = 1'b1;
    bit   stalls_on = 1'b1;
    int   idle_cycles = 0;

    t_cusum_scoreboard sb = new();

    cusum_in_if  in_if ();
    cusum_out_if out_if ();
    cusum_cfg_if cfg_if ();

    cusum_change_detector i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #CLK_HALF clk = ~clk;

    // Handshake monitor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.write_reg(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready)
                sb.note_input(in_if.func, in_if.sample);
            if (out_if.valid && out_if.ready)
                sb.check_result('{out_if.alarm, out_if.pos_sum, out_if.neg_sum});
            if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready) ||
                (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Result side: random stalls that start once a result is offered
    initial begin : result_sink
        int unsigned stall;
        out_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = stalls_on ? $urandom_range(0, 6) : 0;
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                @(posedge clk);
                while (!out_if.valid) @(posedge clk);
                repeat (stall - 1) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            @(posedge clk);
            while (!out_if.valid) @(posedge clk);
            if ($urandom_range(0, 39) == 0)
                stalls_on = !stalls_on;
        end
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] x);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid  <= 1'b1;
        in_if.func   <= f;
        in_if.sample <= x;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    // Hold off input until every expected result is back
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Random stream: a wandering level with noise, plus extremes and commands
    task automatic random_phase(input int n_items);
        int          level;
        int          amp;
        int unsigned pick;
        logic [DATA_W-1:0] x;
        level = int'($urandom_range(0, 400 << 16)) - (200 << 16);
        amp   = 1 << 14;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0) begin
                level = int'($urandom_range(0, 400 << 16)) - (200 << 16);
                case ($urandom_range(0, 3))
                    0: amp = 1 << 8;
                    1: amp = 1 << 14;
                    2: amp = 1 << 16;
                    default: amp = 1 << 18;
                endcase
            end
            if ($urandom_range(0, 49) == 0)
                gaps_on = !gaps_on;
            if ($urandom_range(0, 99) == 0)
                drain_results();
            if (pick < 3)
                send_item(FUNC_RESET, $urandom());
            else if (pick < 5)
                send_item(FUNC_CLEAR, $urandom());
            else if (pick < 7)
                send_item(FUNC_UNUSED, $urandom());
            else if (pick < 12)
                send_item(FUNC_OBSERVE, $urandom());
            else if (pick < 14) begin
                case ($urandom_range(0, 3))
                    0: x = POS_MAX;
                    1: x = NEG_MIN;
                    2: x = '0;
                    default: x = WORD_MAX;
                endcase
                send_item(FUNC_OBSERVE, x);
            end else begin
                x = level + int'($urandom_range(0, 2 * amp)) - amp;
                send_item(FUNC_OBSERVE, x);
            end
        end
    endtask

    initial begin
        logic [DATA_W-1:0] thr;
        logic [DATA_W-1:0] drf;
        rst_n        <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.func   <= FUNC_OBSERVE;
        in_if.sample <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_THRESHOLD;
        cfg_if.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, extreme samples, every command
        send_item(FUNC_OBSERVE, '0);
        send_item(FUNC_OBSERVE, POS_MAX);
        send_item(FUNC_OBSERVE, NEG_MIN);
        send_item(FUNC_OBSERVE, WORD_MAX);
        send_item(FUNC_OBSERVE, 32'd1);
        repeat (3) send_item(FUNC_OBSERVE, 32'd10 << 16);
        send_item(FUNC_UNUSED, WORD_MAX);
        send_item(FUNC_RESET, POS_MAX);
        send_item(FUNC_CLEAR, NEG_MIN);
        send_item(FUNC_UNUSED, '0);

        // Directed: drive the upward sum into saturation with zero drift
        write_reg(CFG_DRIFT, '0);
        write_reg(CFG_THRESHOLD, WORD_MAX);
        send_item(FUNC_CLEAR, '0);
        send_item(FUNC_OBSERVE, NEG_MIN);
        repeat (4) send_item(FUNC_OBSERVE, POS_MAX);
        send_item(FUNC_UNUSED, '0);           // saturated sum equal to threshold: no alarm
        write_reg(CFG_THRESHOLD, WORD_MAX - 1);
        send_item(FUNC_UNUSED, WORD_MAX);     // same sums, one below: alarm
        // Directed: huge drift clips both sums to zero
        write_reg(CFG_DRIFT, WORD_MAX);
        send_item(FUNC_OBSERVE, '0);
        send_item(FUNC_OBSERVE, NEG_MIN);
        write_reg(CFG_THRESHOLD, '0);
        send_item(FUNC_UNUSED, '0);

        // Random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    thr = $urandom_range(1 << 16, 12 << 16);
                    drf = $urandom_range(0, 1 << 16);
                end
                1: begin thr = '0;       drf = '0;       end
                2: begin thr = WORD_MAX; drf = WORD_MAX; end
                3: begin thr = '0;       drf = WORD_MAX; end
                4: begin thr = WORD_MAX; drf = '0;       end
                5: begin
                    thr = $urandom_range(0, 64 << 16);
                    drf = '0;
                end
                default: begin
                    thr = $urandom();
                    drf = $urandom();
                end
            endcase
            write_reg(CFG_THRESHOLD, thr);
            write_reg(CFG_DRIFT, drf);
            random_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (40) @(posedge clk);
        sb.check_empty();
        $display("Covered %0d samples and %0d commands over %0d register writes.",
                 sb.n_observe, sb.n_command, sb.n_cfg);
        $display("Results with alarm: %0d, with a saturated sum: %0d, failures: %0d.",
                 sb.n_alarm, sb.n_sat, sb.errors);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule : tb_cusum_change_detector

// ----- files.f -----
design/cusum_pkg.sv
design/cusum_if.sv
design/cusum_ctrl.sv
design/cusum_dp.sv
design/cusum_change_detector.sv
verif/tb_cusum_change_detector.sv
